// File: sv/hrhs_pkg.sv
`timescale 1ns / 1ps

package hrhs_pkg;

    localparam int METHOD_CAPACITY_DEF = 8;
    localparam int URI_CAPACITY_DEF    = 64;
    localparam int PREFIX_MAX_DEF      = 8;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 64;
    localparam int PLEN_W     = 4;
    localparam int KIND_W     = 3;
    localparam int BYTE_W     = 8;
    localparam int POS_W      = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_BYTES  = 1'b1;

    localparam logic [BYTE_W-1:0] CH_SPACE = 8'd32;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'd13;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'd10;
    localparam logic [BYTE_W-1:0] CH_SLASH = 8'd47;

    localparam logic [KIND_W-1:0] KIND_METHOD_CHAR = 3'd0;
    localparam logic [KIND_W-1:0] KIND_METHOD_END  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_URI_CHAR    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_URI_END     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_HEADER_BYTE = 3'd4;
    localparam logic [KIND_W-1:0] KIND_HEAD_END    = 3'd5;
    localparam logic [KIND_W-1:0] KIND_RESTARTED   = 3'd6;
    localparam logic [KIND_W-1:0] KIND_IGNORED     = 3'd7;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] echo_byte;
        logic [POS_W-1:0]  position;
        logic              cgi_match;
        logic              dir_request;
        logic              overflow;
    } t_result;

endpackage

// File: sv/hrhs_scanner.sv
`timescale 1ns / 1ps

module hrhs_scanner #(
    parameter int METHOD_CAPACITY = hrhs_pkg::METHOD_CAPACITY_DEF,
    parameter int URI_CAPACITY    = hrhs_pkg::URI_CAPACITY_DEF,
    parameter int PREFIX_MAX      = hrhs_pkg::PREFIX_MAX_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_accept,
    input  logic                              i_command,
    input  logic [hrhs_pkg::BYTE_W-1:0]       i_data_byte,
    input  logic [hrhs_pkg::PLEN_W-1:0]       i_prefix_length,
    input  logic [hrhs_pkg::CFG_DATA_W-1:0]   i_prefix_bytes,
    output hrhs_pkg::t_result                 o_result
);

    localparam int CAP_MAX = (METHOD_CAPACITY > URI_CAPACITY) ? METHOD_CAPACITY : URI_CAPACITY;
    localparam int CNT_W   = $clog2(CAP_MAX + 1);
    localparam int EXT_W   = (CNT_W > 7) ? CNT_W : 7;

    typedef enum logic [1:0] {
        PH_METHOD = 2'd0,
        PH_URI    = 2'd1,
        PH_HEADER = 2'd2,
        PH_DONE   = 2'd3
    } t_phase;

    t_phase                        r_phase, n_phase;
    logic [CNT_W-1:0]              r_count, n_count;
    logic                          r_prefix_ok, n_prefix_ok;
    logic                          r_cgi, n_cgi;
    logic [hrhs_pkg::BYTE_W-1:0]   r_last, n_last;
    logic                          r_dir, n_dir;
    logic [2:0]                    r_run_len, n_run_len;
    logic                          r_run_ok, n_run_ok;
    logic                          r_ovf, n_ovf;

    logic [EXT_W-1:0]              count_ext;
    logic [EXT_W-1:0]              plen_ext;
    logic [hrhs_pkg::POS_W-1:0]    count_sat;
    logic [hrhs_pkg::BYTE_W-1:0]   want_byte;
    logic [hrhs_pkg::BYTE_W-1:0]   want_break;
    logic                          run_ok_t;

    always_comb begin
        count_ext = EXT_W'(r_count);
        if (i_prefix_length > hrhs_pkg::PLEN_W'(PREFIX_MAX)) begin
            plen_ext = EXT_W'(PREFIX_MAX);
        end else begin
            plen_ext = EXT_W'(i_prefix_length);
        end
        count_sat = (count_ext > EXT_W'(63)) ? hrhs_pkg::POS_W'(63)
                                             : count_ext[hrhs_pkg::POS_W-1:0];
        want_byte  = i_prefix_bytes[8*r_count[2:0] +: 8];
        want_break = r_run_len[0] ? hrhs_pkg::CH_LF : hrhs_pkg::CH_CR;
        run_ok_t   = r_run_ok && (i_data_byte == want_break);

        n_phase     = r_phase;
        n_count     = r_count;
        n_prefix_ok = r_prefix_ok;
        n_cgi       = r_cgi;
        n_last      = r_last;
        n_dir       = r_dir;
        n_run_len   = r_run_len;
        n_run_ok    = r_run_ok;
        n_ovf       = r_ovf;

        o_result.kind      = hrhs_pkg::KIND_IGNORED;
        o_result.echo_byte = i_data_byte;
        o_result.position  = '0;

        if (i_command) begin
            n_phase     = PH_METHOD;
            n_count     = '0;
            n_prefix_ok = 1'b1;
            n_cgi       = 1'b0;
            n_last      = '0;
            n_dir       = 1'b0;
            n_run_len   = '0;
            n_run_ok    = 1'b1;
            n_ovf       = 1'b0;
            o_result.kind      = hrhs_pkg::KIND_RESTARTED;
            o_result.echo_byte = '0;
        end else begin
            case (r_phase)
                PH_METHOD: begin
                    o_result.position = count_sat;
                    if (i_data_byte != hrhs_pkg::CH_SPACE) begin
                        o_result.kind = hrhs_pkg::KIND_METHOD_CHAR;
                        if (r_count >= CNT_W'(METHOD_CAPACITY)) begin
                            n_ovf = 1'b1;
                        end else begin
                            n_count = r_count + 1'b1;
                        end
                    end else begin
                        o_result.kind = hrhs_pkg::KIND_METHOD_END;
                        n_count = '0;
                        n_phase = PH_URI;
                    end
                end
                PH_URI: begin
                    o_result.position = count_sat;
                    if (i_data_byte != hrhs_pkg::CH_SPACE) begin
                        o_result.kind = hrhs_pkg::KIND_URI_CHAR;
                        if (r_count >= CNT_W'(URI_CAPACITY)) begin
                            n_ovf = 1'b1;
                        end else begin
                            n_count = r_count + 1'b1;
                        end
                        if (count_ext < plen_ext && i_data_byte != want_byte) begin
                            n_prefix_ok = 1'b0;
                        end
                        n_last = i_data_byte;
                    end else begin
                        o_result.kind = hrhs_pkg::KIND_URI_END;
                        n_cgi   = r_prefix_ok && (count_ext >= plen_ext);
                        n_dir   = (r_last == hrhs_pkg::CH_SLASH);
                        n_phase = PH_HEADER;
                    end
                end
                PH_HEADER: begin
                    o_result.kind = hrhs_pkg::KIND_HEADER_BYTE;
                    if (i_data_byte == hrhs_pkg::CH_CR || i_data_byte == hrhs_pkg::CH_LF) begin
                        if (r_run_len < 3'd4) begin
                            n_run_ok  = run_ok_t;
                            n_run_len = r_run_len + 3'd1;
                            if (r_run_len == 3'd3 && run_ok_t) begin
                                o_result.kind = hrhs_pkg::KIND_HEAD_END;
                                n_phase = PH_DONE;
                            end
                        end
                    end else begin
                        n_run_len = '0;
                        n_run_ok  = 1'b1;
                    end
                end
                default: begin
                    o_result.kind = hrhs_pkg::KIND_IGNORED;
                end
            endcase
        end

        o_result.cgi_match   = n_cgi;
        o_result.dir_request = n_dir;
        o_result.overflow    = n_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_METHOD;
            r_count     <= '0;
            r_prefix_ok <= 1'b1;
            r_cgi       <= 1'b0;
            r_last      <= '0;
            r_dir       <= 1'b0;
            r_run_len   <= '0;
            r_run_ok    <= 1'b1;
            r_ovf       <= 1'b0;
        end else if (i_accept) begin
            r_phase     <= n_phase;
            r_count     <= n_count;
            r_prefix_ok <= n_prefix_ok;
            r_cgi       <= n_cgi;
            r_last      <= n_last;
            r_dir       <= n_dir;
            r_run_len   <= n_run_len;
            r_run_ok    <= n_run_ok;
            r_ovf       <= n_ovf;
        end
    end

endmodule

// File: sv/http_request_head_scanner.sv
`timescale 1ns / 1ps

// Scans an HTTP request head one byte per transaction and returns exactly one
// result transaction per input transaction, in order. A byte is taken every
// cycle while o_stall is low; its result is registered in the output
// register, or in the skid stage while the output is stalled. A one-entry
// skid stage behind the output register keeps input acceptance going while a
// result waits, so o_stall rises only once a byte is taken while the output
// side is stalled with a result pending. Configuration writes are always taken
// (o_cfg_ready is high) and must only be issued while the block is idle.
module http_request_head_scanner #(
    parameter int METHOD_CAPACITY = hrhs_pkg::METHOD_CAPACITY_DEF,
    parameter int URI_CAPACITY    = hrhs_pkg::URI_CAPACITY_DEF,
    parameter int PREFIX_MAX      = hrhs_pkg::PREFIX_MAX_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,

    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_command,
    input  logic [hrhs_pkg::BYTE_W-1:0]      i_data_byte,

    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [hrhs_pkg::KIND_W-1:0]      o_kind,
    output logic [hrhs_pkg::BYTE_W-1:0]      o_echo_byte,
    output logic [hrhs_pkg::POS_W-1:0]       o_position,
    output logic                             o_cgi_match,
    output logic                             o_dir_request,
    output logic                             o_overflow,

    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [hrhs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [hrhs_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    logic [hrhs_pkg::PLEN_W-1:0]     r_prefix_length;
    logic [hrhs_pkg::CFG_DATA_W-1:0] r_prefix_bytes;

    hrhs_pkg::t_result step_result;
    hrhs_pkg::t_result r_out;
    hrhs_pkg::t_result r_skid;
    logic              r_out_valid;
    logic              r_skid_valid;
    logic              in_accept;
    logic              out_advance;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = r_skid_valid;
    assign in_accept   = i_valid && !r_skid_valid;
    assign out_advance = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix_length <= '0;
            r_prefix_bytes  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                hrhs_pkg::CFG_PREFIX_LENGTH: r_prefix_length <= i_cfg_data[hrhs_pkg::PLEN_W-1:0];
                hrhs_pkg::CFG_PREFIX_BYTES:  r_prefix_bytes  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    hrhs_scanner #(
        .METHOD_CAPACITY (METHOD_CAPACITY),
        .URI_CAPACITY    (URI_CAPACITY),
        .PREFIX_MAX      (PREFIX_MAX)
    ) u_scanner (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (in_accept),
        .i_command       (i_command),
        .i_data_byte     (i_data_byte),
        .i_prefix_length (r_prefix_length),
        .i_prefix_bytes  (r_prefix_bytes),
        .o_result        (step_result)
    );

    // output register with one-entry skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (out_advance) begin
                if (r_skid_valid) begin
                    r_out        <= r_skid;
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out       <= step_result;
                    r_out_valid <= in_accept;
                end
            end else if (in_accept) begin
                r_skid       <= step_result;
                r_skid_valid <= 1'b1;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_kind        = r_out.kind;
    assign o_echo_byte   = r_out.echo_byte;
    assign o_position    = r_out.position;
    assign o_cgi_match   = r_out.cgi_match;
    assign o_dir_request = r_out.dir_request;
    assign o_overflow    = r_out.overflow;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a result while the output register is empty");

    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == hrhs_pkg::KIND_RESTARTED)
            |-> (!o_cgi_match && !o_dir_request && !o_overflow && o_echo_byte == '0))
        else $error("restart result carries stale flags");

    a_method_no_uri_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_kind == hrhs_pkg::KIND_METHOD_CHAR ||
                     o_kind == hrhs_pkg::KIND_METHOD_END))
            |-> (!o_cgi_match && !o_dir_request))
        else $error("URI flags set during the method");

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import hrhs_pkg::*;

    localparam int ITEMS_PER_SETTING = 135;
    localparam int NUM_SETTINGS      = 6;

    typedef enum logic [1:0] {PH_METHOD, PH_URI, PH_HEADER, PH_DONE} t_scan_phase;

    typedef struct {
        logic             cmd;
        logic [BYTE_W-1:0] data;
    } t_req_byte;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic                  i_command = 1'b0;
    logic [BYTE_W-1:0]     i_data_byte = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [KIND_W-1:0]     o_kind;
    logic [BYTE_W-1:0]     o_echo_byte;
    logic [POS_W-1:0]      o_position;
    logic                  o_cgi_match;
    logic                  o_dir_request;
    logic                  o_overflow;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    http_request_head_scanner DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_command     (i_command),
        .i_data_byte   (i_data_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_kind        (o_kind),
        .o_echo_byte   (o_echo_byte),
        .o_position    (o_position),
        .o_cgi_match   (o_cgi_match),
        .o_dir_request (o_dir_request),
        .o_overflow    (o_overflow),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Scanner state and register copy
    logic [PLEN_W-1:0]     cfg_prefix_len = '0;
    logic [CFG_DATA_W-1:0] cfg_prefix_bytes = '0;
    t_scan_phase           scan_phase;
    int                    char_cnt;
    logic                  prefix_ok;
    logic                  cgi_flag;
    logic [BYTE_W-1:0]     last_uri_byte;
    logic                  dir_flag;
    int                    crlf_run;
    logic                  crlf_ok;
    logic                  ovf_flag;

    t_req_byte pending_bytes[$];
    t_result   scan_results_due[$];

    int bytes_queued = 0;
    int bytes_accepted = 0;
    int setting_items = 0;
    int errors = 0;
    int results_checked = 0;
    int head_ends = 0;
    int restarts = 0;
    int overflow_results = 0;

    int burst_left = 0;
    int gap_left = 0;
    int stall_mode = 0;
    int stall_left = 0;
    int stall_hold = 0;
    logic stall_level = 1'b0;

    function automatic void clear_scan();
        scan_phase    = PH_METHOD;
        char_cnt      = 0;
        prefix_ok     = 1'b1;
        cgi_flag      = 1'b0;
        last_uri_byte = '0;
        dir_flag      = 1'b0;
        crlf_run      = 0;
        crlf_ok       = 1'b1;
        ovf_flag      = 1'b0;
    endfunction

    function automatic logic [POS_W-1:0] pos6(input int v);
        return (v > 63) ? 6'd63 : v[POS_W-1:0];
    endfunction

    function automatic int take_char(input int cap);
        int idx;
        idx = char_cnt;
        if (idx >= cap) ovf_flag = 1'b1;
        else char_cnt = idx + 1;
        return idx;
    endfunction

    function automatic int active_prefix_len();
        return (cfg_prefix_len > PREFIX_MAX_DEF) ? PREFIX_MAX_DEF : int'(cfg_prefix_len);
    endfunction

    function automatic t_result next_scan_result(input logic cmd, input logic [BYTE_W-1:0] b);
        t_result r;
        int      idx;
        r.kind      = KIND_IGNORED;
        r.echo_byte = b;
        r.position  = '0;
        if (cmd) begin
            clear_scan();
            r.kind      = KIND_RESTARTED;
            r.echo_byte = '0;
        end else begin
            case (scan_phase)
                PH_METHOD: begin
                    if (b != CH_SPACE) begin
                        r.kind     = KIND_METHOD_CHAR;
                        r.position = pos6(take_char(METHOD_CAPACITY_DEF));
                    end else begin
                        r.kind     = KIND_METHOD_END;
                        r.position = pos6(char_cnt);
                        char_cnt   = 0;
                        scan_phase = PH_URI;
                    end
                end
                PH_URI: begin
                    if (b != CH_SPACE) begin
                        idx        = take_char(URI_CAPACITY_DEF);
                        r.kind     = KIND_URI_CHAR;
                        r.position = pos6(idx);
                        if (idx < active_prefix_len() && b != cfg_prefix_bytes[8*idx +: 8])
                            prefix_ok = 1'b0;
                        last_uri_byte = b;
                    end else begin
                        r.kind     = KIND_URI_END;
                        r.position = pos6(char_cnt);
                        cgi_flag   = prefix_ok && (char_cnt >= active_prefix_len());
                        dir_flag   = (last_uri_byte == CH_SLASH);
                        scan_phase = PH_HEADER;
                    end
                end
                PH_HEADER: begin
                    r.kind = KIND_HEADER_BYTE;
                    if (b == CH_CR || b == CH_LF) begin
                        if (crlf_run < 4) begin
                            if (b != ((crlf_run % 2) ? CH_LF : CH_CR)) crlf_ok = 1'b0;
                            crlf_run++;
                            if (crlf_run == 4 && crlf_ok) begin
                                r.kind     = KIND_HEAD_END;
                                scan_phase = PH_DONE;
                            end
                        end
                    end else begin
                        crlf_run = 0;
                        crlf_ok  = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        r.cgi_match   = cgi_flag;
        r.dir_request = dir_flag;
        r.overflow    = ovf_flag;
        return r;
    endfunction

    // Stimulus building
    function automatic void queue_byte(input logic cmd, input logic [BYTE_W-1:0] b,
                                       input bit counts);
        t_req_byte item;
        item.cmd  = cmd;
        item.data = b;
        pending_bytes.push_back(item);
        bytes_queued++;
        if (counts) setting_items++;
    endfunction

    function automatic void queue_text(input string s);
        foreach (s[i]) queue_byte(1'b0, s[i], 1'b1);
    endfunction

    function automatic void queue_break();
        queue_byte(1'b0, CH_CR, 1'b1);
        queue_byte(1'b0, CH_LF, 1'b1);
    endfunction

    function automatic logic [BYTE_W-1:0] any_nonspace();
        logic [BYTE_W-1:0] b;
        do b = 8'($urandom); while (b == CH_SPACE);
        return b;
    endfunction

    function automatic logic [BYTE_W-1:0] text_byte();
        if ($urandom_range(0, 3) == 0) return any_nonspace();
        return 8'($urandom_range(33, 126));
    endfunction

    function automatic logic [BYTE_W-1:0] header_byte();
        logic [BYTE_W-1:0] b;
        do b = 8'($urandom); while (b == CH_CR || b == CH_LF);
        return b;
    endfunction

    function automatic void queue_directed();
        queue_byte(1'b1, 8'hFF, 1'b1);
        queue_byte(1'b0, 8'hFF, 1'b1);
        queue_byte(1'b0, 8'h00, 1'b1);
        queue_text("GETTEGX");
        queue_byte(1'b0, CH_SPACE, 1'b1);
        queue_text("/c");
        queue_byte(1'b0, CH_SPACE, 1'b1);
        queue_byte(1'b0, CH_CR, 1'b1);
        queue_byte(1'b0, CH_CR, 1'b1);
        queue_byte(1'b0, CH_LF, 1'b1);
        queue_break();
        queue_text("H");
        queue_break();
        queue_break();
        queue_byte(1'b0, CH_SPACE, 1'b1);
        queue_byte(1'b1, 8'h00, 1'b1);
        queue_byte(1'b0, CH_SPACE, 1'b1);
        queue_byte(1'b0, CH_SPACE, 1'b1);
        queue_byte(1'b1, 8'h5A, 1'b1);
    endfunction

    function automatic void queue_request();
        int                style;
        int                mlen;
        int                ulen;
        int                plen;
        int                nlines;
        int                n;
        bit                use_prefix;
        bit                near_miss;
        logic [BYTE_W-1:0] b;
        plen = active_prefix_len();
        if ($urandom_range(0, 9) != 0) queue_byte(1'b1, 8'($urandom), 1'b1);
        style = $urandom_range(0, 19);
        if (style == 0) begin
            n = $urandom_range(1, 12);
            repeat (n) queue_byte(1'b0, 8'($urandom), 1'b1);
            return;
        end
        case ($urandom_range(0, 9))
            0:       mlen = 0;
            1:       mlen = $urandom_range(9, 12);
            default: mlen = $urandom_range(1, 8);
        endcase
        repeat (mlen) queue_byte(1'b0, text_byte(), 1'b1);
        queue_byte(1'b0, CH_SPACE, 1'b1);
        if (style == 1) begin
            queue_byte(1'b1, 8'($urandom), 1'b1);
            return;
        end
        case ($urandom_range(0, 11))
            0:       ulen = 0;
            1:       ulen = $urandom_range(60, 70);
            2:       ulen = (plen > 0) ? plen - 1 : 0;
            default: ulen = $urandom_range(1, 12);
        endcase
        use_prefix = ($urandom_range(0, 2) != 0);
        near_miss  = ($urandom_range(0, 4) == 0);
        for (int i = 0; i < ulen; i++) begin
            if (use_prefix && i < plen) begin
                b = cfg_prefix_bytes[8*i +: 8];
                if (near_miss && i == plen - 1) b ^= 8'(1 << $urandom_range(0, 7));
                if (b == CH_SPACE) b = text_byte();
            end else if (i == ulen - 1 && $urandom_range(0, 1) == 0) begin
                b = CH_SLASH;
            end else begin
                b = text_byte();
            end
            queue_byte(1'b0, b, 1'b1);
        end
        queue_byte(1'b0, CH_SPACE, 1'b1);
        nlines = $urandom_range(0, 3);
        repeat (nlines) begin
            n = $urandom_range(1, 10);
            repeat (n) queue_byte(1'b0, header_byte(), 1'b1);
            if ($urandom_range(0, 7) == 0) begin
                n = $urandom_range(2, 6);
                repeat (n) queue_byte(1'b0, $urandom_range(0, 1) ? CH_CR : CH_LF, 1'b1);
            end else begin
                queue_break();
            end
        end
        if (style != 2) begin
            queue_break();
            queue_break();
        end
        n = $urandom_range(0, 3);
        repeat (n) queue_byte(1'b0, 8'($urandom), 1'b0);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_prefix();
        logic [CFG_DATA_W-1:0] v;
        for (int i = 0; i < 8; i++) v[8*i +: 8] = text_byte();
        return v;
    endfunction

    task automatic load_prefix(input logic [PLEN_W-1:0] len, input logic [CFG_DATA_W-1:0] bytes);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_PREFIX_LENGTH;
        i_cfg_data  <= CFG_DATA_W'(len);
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_prefix_len = len;
        i_cfg_index <= CFG_PREFIX_BYTES;
        i_cfg_data  <= bytes;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_prefix_bytes = bytes;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (bytes_accepted != bytes_queued || scan_results_due.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // Sender: bursts with random gaps, payload held while stalled
    always @(posedge i_clk) begin
        t_req_byte item;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                scan_results_due.push_back(next_scan_result(i_command, i_data_byte));
                bytes_accepted++;
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pending_bytes.size() != 0) begin
                    item = pending_bytes.pop_front();
                    i_valid     <= 1'b1;
                    i_command   <= item.cmd;
                    i_data_byte <= item.data;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else if ($urandom_range(0, 9) == 0) begin
                        burst_left = $urandom_range(100, 300);
                        gap_left   = 0;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 :
                                     ($urandom_range(0, 7) == 0) ? $urandom_range(8, 25) :
                                     $urandom_range(1, 6);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall pattern: free running, random, long holds, alternating
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(50, 400);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            2: begin
                if (stall_hold == 0) begin
                    stall_level = ~stall_level;
                    stall_hold  = $urandom_range(1, 12);
                end else begin
                    stall_hold--;
                end
                i_stall <= stall_level;
            end
            default: i_stall <= ~i_stall;
        endcase
    end

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (scan_results_due.size() == 0) begin
                errors++;
                $display("%0t: no transaction expected, actual kind %0h byte %0h",
                         $time, o_kind, o_echo_byte);
            end else begin
                want = scan_results_due.pop_front();
                check_field("kind", 8'(want.kind), 8'(o_kind));
                check_field("echo_byte", want.echo_byte, o_echo_byte);
                check_field("position", 8'(want.position), 8'(o_position));
                check_field("cgi_match", 8'(want.cgi_match), 8'(o_cgi_match));
                check_field("dir_request", 8'(want.dir_request), 8'(o_dir_request));
                check_field("overflow", 8'(want.overflow), 8'(o_overflow));
                results_checked++;
                if (want.kind == KIND_HEAD_END) head_ends++;
                if (want.kind == KIND_RESTARTED) restarts++;
                if (want.overflow) overflow_results++;
            end
        end
    end

    initial begin
        logic [PLEN_W-1:0]     len;
        logic [CFG_DATA_W-1:0] bytes;
        clear_scan();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int s = 0; s < NUM_SETTINGS; s++) begin
            case (s)
                0: begin len = 4'd3;  bytes = 64'h0000_0000_0067_632F; end
                1: begin len = 4'd0;  bytes = '0; end
                2: begin len = 4'd15; bytes = random_prefix(); end
                3: begin len = 4'd8;  bytes = '1; end
                4: begin len = 4'd1;  bytes = random_prefix(); end
                default: begin
                    len   = PLEN_W'($urandom_range(2, 9));
                    bytes = random_prefix();
                end
            endcase
            load_prefix(len, bytes);
            setting_items = 0;
            if (s == 0) queue_directed();
            while (setting_items < ITEMS_PER_SETTING) queue_request();
            wait_drained();
        end
        $display("checked %0d result transactions over %0d prefix settings", results_checked,
                 NUM_SETTINGS);
        $display("head ends %0d, restarts %0d, results with overflow set %0d", head_ends,
                 restarts, overflow_results);
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("timeout at %0t", $time);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
